FILE: rtl/periodic_coulomb_force_sum_macros.svh
// Assertion macros for the periodic Coulomb force sum block.
// They expect clk_i and rst_ni in the scope where they are used.
`ifndef PERIODIC_COULOMB_FORCE_SUM_MACROS_SVH
`define PERIODIC_COULOMB_FORCE_SUM_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define PCFS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the following cycle.
`define PCFS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pcfs_pkg.sv
// Shared types and constants of the periodic Coulomb force sum block.
// No dependencies; every other file but the macro header imports it.
`default_nettype none

package pcfs_pkg;

  // Request codes carried by req_type.
  typedef enum logic [1:0] {
    REQ_LOAD_ATOM    = 2'd0,
    REQ_LOAD_LATTICE = 2'd1,
    REQ_COMPUTE      = 2'd2
  } req_type_e;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ATOM_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_A   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_B   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_C   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF     = 3'd4;
  localparam int CFG_DATA_W = 32;

  localparam int SLOT_W     = 6;
  localparam int ATOM_CNT_W = 7;
  localparam logic [SLOT_W-1:0] LAT_SLOT_MAX = 6'd2;

  // Iteration counts of the serial units.
  localparam int SQRT_STEPS = 32;
  localparam int UDIV_STEPS = 31;
  localparam int MDIV_STEPS = 49;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [5:0]         slot;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic signed [31:0] nucleus_charge;
    logic signed [31:0] electron_charge;
    logic signed [31:0] interstitial_density;
    logic [30:0]        cell_volume;
  } pcfs_in_t;

  typedef struct packed {
    logic [5:0]         atom_index;
    logic signed [47:0] force_x;
    logic signed [47:0] force_y;
    logic signed [47:0] force_z;
    logic               last;
  } pcfs_out_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LD_WR, S_AT_RD, S_AT_LAT, S_PR_RD, S_PR_LAT, S_PR_CHK,
    S_SH_CHK, S_D_CMP, S_FAR, S_D2, S_LIM, S_SQRT, S_R2, S_U_INIT,
    S_U_DIV, S_MUL_LO, S_MUL_HI, S_M_INIT, S_M_DIV, S_ACC, S_NEXT, S_EMIT
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              in_load;
    logic              atom_wr;
    logic              lat_wr;
    logic              rd_en;
    logic [SLOT_W-1:0] addr;
    logic              own_lat;
    logic              pair_lat;
    logic              sh_init;
    logic              sh_step;
    logic              d_comp;
    logic              d2_clr;
    logic              d2_acc;
    logic              sq_init;
    logic              sq_step;
    logic              r2_ld;
    logic              ud_init;
    logic              md_init;
    logic              dv_step;
    logic              mul_lo;
    logic              mul_hi;
    logic              acc_add;
    logic [1:0]        comp;
  } pcfs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic                  sh_last;
    logic                  sh_zero;
    logic                  no_shift;
    logic                  q_zero;
    logic                  far;
    logic                  d2_skip;
    logic [ATOM_CNT_W-1:0] n_atoms;
  } pcfs_sts_t;

endpackage

`default_nettype wire

FILE: rtl/pcfs_if.sv
// Valid/ready channel interfaces for request and result items.
// Depends on pcfs_pkg for the payload types.
`default_nettype none

interface pcfs_in_if;
  import pcfs_pkg::*;
  logic     valid;
  logic     ready;
  pcfs_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pcfs_out_if;
  import pcfs_pkg::*;
  logic      valid;
  logic      ready;
  pcfs_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/pcfs_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Used for the unit vector and the force magnitude; depends on pcfs_pkg.
`default_nettype none

module pcfs_div (
  input  wire logic        clk_i,
  input  wire logic        init_i,
  input  wire logic [63:0] rem_init_i,
  input  wire logic [63:0] div_init_i,
  input  wire logic [48:0] num_init_i,
  input  wire logic        step_i,
  output logic [48:0]      quo_o,
  output logic             sat_o
);
  import pcfs_pkg::*;

  logic [63:0] rem_q, rem_d;
  logic [63:0] div_q;
  logic [48:0] num_q;
  logic [48:0] quo_q, quo_d;
  logic        sat_q;
  logic [64:0] rem_sh;
  logic [64:0] rem_sub;

  // One restoring step: bring down the next numerator bit and try to subtract.
  always_comb begin
    rem_sh  = {rem_q, num_q[48]};
    rem_sub = rem_sh - {1'b0, div_q};
    if (rem_sh >= {1'b0, div_q}) begin
      rem_d = rem_sub[63:0];
      quo_d = {quo_q[47:0], 1'b1};
    end else begin
      rem_d = rem_sh[63:0];
      quo_d = {quo_q[47:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (init_i) begin
      rem_q <= rem_init_i;
      div_q <= div_init_i;
      num_q <= num_init_i;
      quo_q <= '0;
      sat_q <= (rem_init_i >= div_init_i);
    end else if (step_i) begin
      rem_q <= rem_d;
      num_q <= {num_q[47:0], 1'b0};
      quo_q <= quo_d;
    end
  end

  assign quo_o = quo_q;
  assign sat_o = sat_q;

endmodule

`default_nettype wire

FILE: rtl/pcfs_dp.sv
// Datapath: atom memory, lattice and configuration registers, distance,
// square root, shared divider, force terms and saturating accumulators.
// Depends on pcfs_pkg and pcfs_div.
`default_nettype none

module pcfs_dp #(
  parameter int MAX_ATOMS  = 64,
  parameter int MAX_REPEAT = 15
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire pcfs_pkg::pcfs_cmd_t          cmd_i,
  input  wire pcfs_pkg::pcfs_in_t           in_data_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [pcfs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [pcfs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output pcfs_pkg::pcfs_sts_t               sts_o,
  output logic signed [47:0]                force_x_o,
  output logic signed [47:0]                force_y_o,
  output logic signed [47:0]                force_z_o
);
  import pcfs_pkg::*;

  localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int RW = $clog2(MAX_REPEAT + 1) + 1;
  localparam int PW = RW + 32;
  localparam int DW = PW + 3;
  localparam logic [48:0] MAG_MAX = 49'h1_0000_0000_0000;
  localparam logic signed [49:0] ACC_HI = 50'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [49:0] ACC_LO = 50'sh3_8000_0000_0000;

  // Configuration registers.
  logic [ATOM_CNT_W-1:0] atom_count_q;
  logic [3:0]            rep_q [3];
  logic [31:0]           cutoff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atom_count_q <= 7'd1;
      rep_q[0]     <= 4'd1;
      rep_q[1]     <= 4'd1;
      rep_q[2]     <= 4'd1;
      cutoff_q     <= 32'd10000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ATOM_COUNT: atom_count_q <= cfg_data_i[6:0];
        CFG_REPEAT_A:   rep_q[0]     <= cfg_data_i[3:0];
        CFG_REPEAT_B:   rep_q[1]     <= cfg_data_i[3:0];
        CFG_REPEAT_C:   rep_q[2]     <= cfg_data_i[3:0];
        CFG_CUTOFF:     cutoff_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamped repeat bounds and their derived limits.
  logic signed [RW-1:0] rep_eff [3];
  logic signed [RW-1:0] rep_m1 [3];
  logic signed [RW-1:0] rep_neg [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rep_eff[k] = (int'(rep_q[k]) > MAX_REPEAT) ? RW'(MAX_REPEAT) : RW'(rep_q[k]);
      rep_m1[k]  = rep_eff[k] - RW'(1);
      rep_neg[k] = -rep_eff[k];
    end
  end

  // Load path: register the fields and the density-volume product.
  logic signed [31:0] ld_x_q, ld_y_q, ld_z_q, ld_nuc_q, ld_ele_q;
  logic signed [63:0] ld_prod_q;
  logic [SLOT_W-1:0]  ld_slot_q;
  logic signed [63:0] ld_mul;
  logic signed [63:0] ld_round;
  logic signed [63:0] ld_shift;
  logic signed [49:0] q_sum;
  logic signed [31:0] q_sat;

  assign ld_mul = 64'(in_data_i.interstitial_density) *
                  64'($signed({1'b0, in_data_i.cell_volume}));

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      ld_x_q    <= in_data_i.coord_x;
      ld_y_q    <= in_data_i.coord_y;
      ld_z_q    <= in_data_i.coord_z;
      ld_nuc_q  <= in_data_i.nucleus_charge;
      ld_ele_q  <= in_data_i.electron_charge;
      ld_slot_q <= in_data_i.slot;
      ld_prod_q <= ld_mul;
    end
  end

  // Round the product to Q16.16 and saturate the effective charge.
  always_comb begin
    ld_round = ld_prod_q + 64'sd32768;
    ld_shift = ld_round >>> 16;
    q_sum    = 50'(ld_nuc_q) - 50'(ld_ele_q) + 50'(ld_shift);
    if (q_sum > 50'sd2147483647) begin
      q_sat = 32'sh7FFF_FFFF;
    end else if (q_sum < -50'sd2147483648) begin
      q_sat = 32'sh8000_0000;
    end else begin
      q_sat = 32'(q_sum);
    end
  end

  // Atom memory: position and charge in one word, registered read.
  logic [127:0] mem [MAX_ATOMS];
  logic [127:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.atom_wr) begin
      mem[ld_slot_q[AW-1:0]] <= {ld_x_q, ld_y_q, ld_z_q, q_sat};
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[cmd_i.addr[AW-1:0]];
    end
  end

  // Lattice vectors, one register per component.
  logic signed [31:0] lat_q [3][3];

  always_ff @(posedge clk_i) begin
    if (cmd_i.lat_wr) begin
      case (in_data_i.slot[1:0])
        2'd0: lat_q[0] <= '{in_data_i.coord_x, in_data_i.coord_y, in_data_i.coord_z};
        2'd1: lat_q[1] <= '{in_data_i.coord_x, in_data_i.coord_y, in_data_i.coord_z};
        2'd2: lat_q[2] <= '{in_data_i.coord_x, in_data_i.coord_y, in_data_i.coord_z};
        default: ;
      endcase
    end
  end

  // Own atom and pair setup.
  logic signed [31:0] pos_i_q [3];
  logic signed [31:0] qi_q;
  logic signed [32:0] base_q [3];
  logic [62:0]        qq_q;
  logic               qneg_q;
  logic               qzero_q;
  logic signed [31:0] pos_j [3];
  logic signed [31:0] qj;
  logic [31:0]        abs_i, abs_j;
  logic [63:0]        qq_full;

  always_comb begin
    pos_j[0] = rd_q[127:96];
    pos_j[1] = rd_q[95:64];
    pos_j[2] = rd_q[63:32];
    qj       = rd_q[31:0];
    abs_i    = qi_q[31] ? 32'(-qi_q) : 32'(qi_q);
    abs_j    = qj[31] ? 32'(-qj) : 32'(qj);
    qq_full  = 64'(abs_i) * 64'(abs_j);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.own_lat) begin
      pos_i_q[0] <= rd_q[127:96];
      pos_i_q[1] <= rd_q[95:64];
      pos_i_q[2] <= rd_q[63:32];
      qi_q       <= rd_q[31:0];
    end
    if (cmd_i.pair_lat) begin
      for (int c = 0; c < 3; c++) begin
        base_q[c] <= 33'(pos_i_q[c]) - 33'(pos_j[c]);
      end
      qq_q    <= qq_full[62:0];
      qneg_q  <= qi_q[31] ^ qj[31];
      qzero_q <= (qi_q == 32'sd0) || (qj == 32'sd0);
    end
  end

  // Image shift counters, last axis innermost.
  logic signed [RW-1:0] sh_q [3];
  logic signed [RW-1:0] sh_d [3];
  logic                 carry;

  always_comb begin
    sh_d  = sh_q;
    carry = 1'b1;
    if (cmd_i.sh_init) begin
      sh_d = rep_neg;
    end else if (cmd_i.sh_step) begin
      for (int k = 2; k >= 0; k--) begin
        if (carry) begin
          if (sh_q[k] == rep_m1[k]) begin
            sh_d[k] = rep_neg[k];
          end else begin
            sh_d[k] = sh_q[k] + RW'(1);
            carry   = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
  end

  // Component selection for the serial steps.
  logic signed [31:0] lat_sel [3];
  logic signed [32:0] base_sel;
  logic signed [PW-1:0] prod [3];
  logic signed [DW-1:0] d_new;
  logic signed [DW-1:0] d_q [3];
  logic [DW-1:0]        ad_full [3];
  logic [31:0]          ad_sel;
  logic                 dneg_sel;
  logic signed [47:0]   acc_sel;
  logic signed [47:0]   acc_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      case (cmd_i.comp)
        2'd0:    lat_sel[k] = lat_q[k][0];
        2'd1:    lat_sel[k] = lat_q[k][1];
        default: lat_sel[k] = lat_q[k][2];
      endcase
      prod[k] = PW'(sh_q[k]) * PW'(lat_sel[k]);
    end
    for (int c = 0; c < 3; c++) begin
      ad_full[c] = d_q[c][DW-1] ? DW'(-d_q[c]) : DW'(d_q[c]);
    end
    case (cmd_i.comp)
      2'd0: begin
        base_sel = base_q[0];
        ad_sel   = ad_full[0][31:0];
        dneg_sel = d_q[0][DW-1];
        acc_sel  = acc_q[0];
      end
      2'd1: begin
        base_sel = base_q[1];
        ad_sel   = ad_full[1][31:0];
        dneg_sel = d_q[1][DW-1];
        acc_sel  = acc_q[1];
      end
      default: begin
        base_sel = base_q[2];
        ad_sel   = ad_full[2][31:0];
        dneg_sel = d_q[2][DW-1];
        acc_sel  = acc_q[2];
      end
    endcase
    d_new = DW'(base_sel) - DW'(prod[0]) - DW'(prod[1]) - DW'(prod[2]);
  end

  // Difference vector, one component a cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.d_comp) begin
      d_q[cmd_i.comp] <= d_new;
    end
  end

  // Squared distance with saturation, one component a cycle.
  logic [63:0] d2_q;
  logic [63:0] ad_sq;
  logic [64:0] d2_sum;

  assign ad_sq  = 64'(ad_sel) * 64'(ad_sel);
  assign d2_sum = {1'b0, d2_q} + {1'b0, ad_sq};

  always_ff @(posedge clk_i) begin
    if (cmd_i.d2_clr) begin
      d2_q <= '0;
    end else if (cmd_i.d2_acc) begin
      d2_q <= d2_sum[64] ? '1 : d2_sum[63:0];
    end
  end

  // Integer square root, two radicand bits a cycle.
  logic [34:0] sq_rem_q;
  logic [31:0] root_q;
  logic [63:0] sq_val_q;
  logic [34:0] sq_sh;
  logic [34:0] sq_trial;

  assign sq_sh    = {sq_rem_q[32:0], sq_val_q[63:62]};
  assign sq_trial = {1'b0, root_q, 2'b01};

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_init) begin
      sq_rem_q <= '0;
      root_q   <= '0;
      sq_val_q <= d2_q;
    end else if (cmd_i.sq_step) begin
      sq_val_q <= {sq_val_q[61:0], 2'b00};
      if (sq_sh >= sq_trial) begin
        sq_rem_q <= sq_sh - sq_trial;
        root_q   <= {root_q[30:0], 1'b1};
      end else begin
        sq_rem_q <= sq_sh;
        root_q   <= {root_q[30:0], 1'b0};
      end
    end
  end

  logic [63:0] r2_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.r2_ld) begin
      r2_q <= 64'(root_q) * 64'(root_q);
    end
  end

  // Shared divider: unit vector component, then term magnitude.
  logic [93:0] prod_q;
  logic [48:0] dv_quo;
  logic        dv_sat;
  logic [63:0] dv_rem_init;
  logic [63:0] dv_div_init;
  logic [48:0] dv_num_init;
  logic [62:0] p_lo;
  logic [61:0] p_hi;

  always_comb begin
    if (cmd_i.md_init) begin
      dv_rem_init = {24'b0, prod_q[93:54]};
      dv_div_init = r2_q;
      dv_num_init = prod_q[53:5];
    end else begin
      dv_rem_init = {33'b0, ad_sel[31:1]};
      dv_div_init = {32'b0, root_q};
      dv_num_init = {ad_sel[0], 48'b0};
    end
  end

  pcfs_div u_div (
    .clk_i      (clk_i),
    .init_i     (cmd_i.ud_init | cmd_i.md_init),
    .rem_init_i (dv_rem_init),
    .div_init_i (dv_div_init),
    .num_init_i (dv_num_init),
    .step_i     (cmd_i.dv_step),
    .quo_o      (dv_quo),
    .sat_o      (dv_sat)
  );

  // Charge product times unit component, in two partial products.
  assign p_lo = 63'(qq_q[31:0]) * 63'(dv_quo[30:0]);
  assign p_hi = 62'(qq_q[62:32]) * 62'(dv_quo[30:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_lo) begin
      prod_q <= 94'(p_lo);
    end else if (cmd_i.mul_hi) begin
      prod_q <= prod_q + {p_hi, 32'b0};
    end
  end

  // Clamp the magnitude and add it to, or subtract it from, the saturating accumulator.
  logic [48:0]        mag;
  logic signed [49:0] acc_sum;

  always_comb begin
    if (dv_sat || (dv_quo > MAG_MAX)) begin
      mag = MAG_MAX;
    end else begin
      mag = dv_quo;
    end
    if (qneg_q ^ dneg_sel) begin
      acc_sum = 50'(acc_sel) - $signed({1'b0, mag});
    end else begin
      acc_sum = 50'(acc_sel) + $signed({1'b0, mag});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q[0] <= '0;
      acc_q[1] <= '0;
      acc_q[2] <= '0;
    end else if (cmd_i.own_lat) begin
      acc_q[0] <= '0;
      acc_q[1] <= '0;
      acc_q[2] <= '0;
    end else if (cmd_i.acc_add) begin
      if (acc_sum > ACC_HI) begin
        acc_q[cmd_i.comp] <= 48'sh7FFF_FFFF_FFFF;
      end else if (acc_sum < ACC_LO) begin
        acc_q[cmd_i.comp] <= 48'sh8000_0000_0000;
      end else begin
        acc_q[cmd_i.comp] <= 48'(acc_sum);
      end
    end
  end

  // Status towards the controller.
  always_comb begin
    sts_o.sh_last  = (sh_q[0] == rep_m1[0]) && (sh_q[1] == rep_m1[1]) &&
                     (sh_q[2] == rep_m1[2]);
    sts_o.sh_zero  = (sh_q[0] == '0) && (sh_q[1] == '0) && (sh_q[2] == '0);
    sts_o.no_shift = (rep_eff[0] == '0) || (rep_eff[1] == '0) || (rep_eff[2] == '0);
    sts_o.q_zero   = qzero_q;
    sts_o.far      = (|ad_full[0][DW-1:32]) || (|ad_full[1][DW-1:32]) ||
                     (|ad_full[2][DW-1:32]);
    sts_o.d2_skip  = (d2_q > {cutoff_q, 32'b0}) || (d2_q == 64'd0);
    sts_o.n_atoms  = (int'(atom_count_q) > MAX_ATOMS) ? ATOM_CNT_W'(MAX_ATOMS)
                                                      : atom_count_q;
  end

  assign force_x_o = acc_q[0];
  assign force_y_o = acc_q[1];
  assign force_z_o = acc_q[2];

endmodule

`default_nettype wire

FILE: rtl/pcfs_ctrl.sv
// Controller state machine: sequences loads, the pair and shift walk,
// the serial units and the result handshake. Depends on pcfs_pkg.
`default_nettype none

module pcfs_ctrl #(
  parameter int MAX_ATOMS = 64
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire logic [1:0]                  in_req_i,
  input  wire logic [pcfs_pkg::SLOT_W-1:0] in_slot_i,
  output logic                             in_ready_o,
  input  wire logic                        out_ready_i,
  output logic                             out_valid_o,
  output logic                             out_last_o,
  output logic [pcfs_pkg::SLOT_W-1:0]      out_index_o,
  input  wire pcfs_pkg::pcfs_sts_t         sts_i,
  output pcfs_pkg::pcfs_cmd_t              cmd_o
);
  import pcfs_pkg::*;

  ctrl_state_e           state_q, state_d;
  logic [ATOM_CNT_W-1:0] i_q, j_q;
  logic [5:0]            cnt_q;
  logic [1:0]            comp_q;
  logic                  in_acc;
  logic                  i_last, j_last;
  logic                  slot_ok;
  logic                  j_adv;

  assign in_acc  = in_valid_i && (state_q == S_IDLE);
  assign i_last  = ((i_q + 7'd1) == sts_i.n_atoms);
  assign j_last  = ((j_q + 7'd1) == sts_i.n_atoms);
  assign slot_ok = ({1'b0, in_slot_i} < ATOM_CNT_W'(MAX_ATOMS));
  assign j_adv   = ((state_q == S_PR_CHK) && (sts_i.q_zero || sts_i.no_shift)) ||
                   ((state_q == S_NEXT) && sts_i.sh_last);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_req_i)
            REQ_LOAD_ATOM: if (slot_ok) state_d = S_LD_WR;
            REQ_COMPUTE:   if (sts_i.n_atoms != '0) state_d = S_AT_RD;
            default: ;
          endcase
        end
      end
      S_LD_WR:  state_d = S_IDLE;
      S_AT_RD:  state_d = S_AT_LAT;
      S_AT_LAT: state_d = S_PR_RD;
      S_PR_RD:  state_d = S_PR_LAT;
      S_PR_LAT: state_d = S_PR_CHK;
      S_PR_CHK: begin
        if (sts_i.q_zero || sts_i.no_shift) begin
          state_d = j_last ? S_EMIT : S_PR_RD;
        end else begin
          state_d = S_SH_CHK;
        end
      end
      S_SH_CHK: state_d = ((i_q == j_q) && sts_i.sh_zero) ? S_NEXT : S_D_CMP;
      S_D_CMP:  if (comp_q == 2'd2) state_d = S_FAR;
      S_FAR:    state_d = sts_i.far ? S_NEXT : S_D2;
      S_D2:     if (comp_q == 2'd2) state_d = S_LIM;
      S_LIM:    state_d = sts_i.d2_skip ? S_NEXT : S_SQRT;
      S_SQRT:   if (cnt_q == 6'(SQRT_STEPS - 1)) state_d = S_R2;
      S_R2:     state_d = S_U_INIT;
      S_U_INIT: state_d = S_U_DIV;
      S_U_DIV:  if (cnt_q == 6'(UDIV_STEPS - 1)) state_d = S_MUL_LO;
      S_MUL_LO: state_d = S_MUL_HI;
      S_MUL_HI: state_d = S_M_INIT;
      S_M_INIT: state_d = S_M_DIV;
      S_M_DIV:  if (cnt_q == 6'(MDIV_STEPS - 1)) state_d = S_ACC;
      S_ACC:    state_d = (comp_q == 2'd2) ? S_NEXT : S_U_INIT;
      S_NEXT: begin
        if (sts_i.sh_last) begin
          state_d = j_last ? S_EMIT : S_PR_RD;
        end else begin
          state_d = S_SH_CHK;
        end
      end
      S_EMIT:   if (out_ready_i) state_d = i_last ? S_IDLE : S_AT_RD;
      default:  state_d = S_IDLE;
    endcase
  end

  // Commands and handshake outputs.
  always_comb begin
    cmd_o       = '0;
    cmd_o.comp  = comp_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.in_load = in_acc && (in_req_i == REQ_LOAD_ATOM);
        cmd_o.lat_wr  = in_acc && (in_req_i == REQ_LOAD_LATTICE) &&
                        (in_slot_i <= LAT_SLOT_MAX);
      end
      S_LD_WR:  cmd_o.atom_wr = 1'b1;
      S_AT_RD: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.addr  = i_q[SLOT_W-1:0];
      end
      S_AT_LAT: cmd_o.own_lat = 1'b1;
      S_PR_RD: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.addr  = j_q[SLOT_W-1:0];
      end
      S_PR_LAT: begin
        cmd_o.pair_lat = 1'b1;
        cmd_o.sh_init  = 1'b1;
      end
      S_D_CMP:  cmd_o.d_comp  = 1'b1;
      S_FAR:    cmd_o.d2_clr  = 1'b1;
      S_D2:     cmd_o.d2_acc  = 1'b1;
      S_LIM:    cmd_o.sq_init = 1'b1;
      S_SQRT:   cmd_o.sq_step = 1'b1;
      S_R2:     cmd_o.r2_ld   = 1'b1;
      S_U_INIT: cmd_o.ud_init = 1'b1;
      S_U_DIV:  cmd_o.dv_step = 1'b1;
      S_MUL_LO: cmd_o.mul_lo  = 1'b1;
      S_MUL_HI: cmd_o.mul_hi  = 1'b1;
      S_M_INIT: cmd_o.md_init = 1'b1;
      S_M_DIV:  cmd_o.dv_step = 1'b1;
      S_ACC:    cmd_o.acc_add = 1'b1;
      S_NEXT:   cmd_o.sh_step = !sts_i.sh_last;
      S_EMIT:   out_valid_o   = 1'b1;
      default: ;
    endcase
  end

  assign out_last_o  = i_last;
  assign out_index_o = i_q[SLOT_W-1:0];

  // State, atom and pair counters, step and component counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      cnt_q   <= '0;
      comp_q  <= '0;
    end else begin
      state_q <= state_d;
      if ((state_q == S_SQRT) || (state_q == S_U_DIV) || (state_q == S_M_DIV)) begin
        cnt_q <= cnt_q + 6'd1;
      end else begin
        cnt_q <= '0;
      end
      case (state_q)
        S_D_CMP, S_D2, S_ACC: comp_q <= (comp_q == 2'd2) ? 2'd0 : comp_q + 2'd1;
        S_SH_CHK, S_LIM:      comp_q <= 2'd0;
        default: ;
      endcase
      if (in_acc && (in_req_i == REQ_COMPUTE)) begin
        i_q <= '0;
      end else if ((state_q == S_EMIT) && out_ready_i) begin
        i_q <= i_q + 7'd1;
      end
      if (state_q == S_AT_LAT) begin
        j_q <= '0;
      end else if (j_adv) begin
        j_q <= j_q + 7'd1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/periodic_coulomb_force_sum.sv
// Periodic Coulomb force sum, top level: controller and datapath.
// Depends on pcfs_pkg, pcfs_if, pcfs_ctrl, pcfs_dp and the macro header.
//
// Usage. Request items arrive on in_i. A load-atom item stores a position
// and the effective charge. A lattice item stores one lattice vector. A
// compute item walks every atom pair and every image shift and then
// delivers one force item per atom on out_o, in atom order, with last set
// on the final one. The block takes one request item at a time; ready is
// low until the previous item has finished.
// Work of a compute item: per atom i, a fetch of the atom and delivery of
// its force item, plus any receiver stall; per partner j, a fetch and a
// check, after which a partner with zero charge or a zero repeat is done.
// Per shift the self pair is skipped; a far component, a pair beyond the
// cutoff or a coincident pair ends the shift early; a formed term takes a
// square root and, per component, two divisions in the shared divider.
// Shifts per pair are 8 * repeat_a * repeat_b * repeat_c.
// Reset clears the controller and sets the registers to their reset values;
// atom and lattice storage holds nothing defined until written.
// A stalled receiver holds the current force item and the walk waits.
`default_nettype none
`include "periodic_coulomb_force_sum_macros.svh"

module periodic_coulomb_force_sum #(
  parameter int MAX_ATOMS  = 64,
  parameter int MAX_REPEAT = 15
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  pcfs_in_if.sink                              in_i,
  pcfs_out_if.source                           out_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [pcfs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [pcfs_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import pcfs_pkg::*;

  pcfs_cmd_t          cmd;
  pcfs_sts_t          sts;
  logic               out_last;
  logic [SLOT_W-1:0]  out_index;
  logic signed [47:0] fx, fy, fz;

  pcfs_ctrl #(
    .MAX_ATOMS (MAX_ATOMS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_req_i    (in_i.data.req_type),
    .in_slot_i   (in_i.data.slot),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_last_o  (out_last),
    .out_index_o (out_index),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pcfs_dp #(
    .MAX_ATOMS  (MAX_ATOMS),
    .MAX_REPEAT (MAX_REPEAT)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_i.data),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sts_o      (sts),
    .force_x_o  (fx),
    .force_y_o  (fy),
    .force_z_o  (fz)
  );

  // Result payload.
  always_comb begin
    out_o.data.atom_index = out_index;
    out_o.data.force_x    = fx;
    out_o.data.force_y    = fy;
    out_o.data.force_z    = fz;
    out_o.data.last       = out_last;
  end

  // Assertions.
  `PCFS_ASSERT_IMP(a_no_overlap, in_i.ready, !out_o.valid, "request taken during results")
  `PCFS_ASSERT_NXT(a_last_idle, out_o.valid && out_o.ready && out_o.data.last, in_i.ready, "not idle after final item")
  `PCFS_ASSERT_NXT(a_mid_gap, out_o.valid && out_o.ready && !out_o.data.last, !out_o.valid && !in_i.ready, "walk did not resume")
  `PCFS_ASSERT_NXT(a_load_busy, in_i.valid && in_i.ready && (in_i.data.req_type == REQ_LOAD_ATOM) && (in_i.data.slot < MAX_ATOMS), !in_i.ready, "atom write skipped")

endmodule

`default_nettype wire
